// ===== hw/rtl/tic_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the traffic intersection controller
// no dependencies

package tic_pkg;

   localparam int unsigned SAMPLE_W = 10;
   localparam int unsigned COLOR_W  = 2;
   localparam int unsigned COUNT_W  = 4;
   localparam int unsigned PHASE_W  = 5;
   localparam int unsigned REQ_W    = 16;
   localparam int unsigned RSP_W    = 24;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd717;

   localparam logic [COLOR_W-1:0] LAMP_OFF    = 2'd0;
   localparam logic [COLOR_W-1:0] LAMP_RED    = 2'd1;
   localparam logic [COLOR_W-1:0] LAMP_GREEN  = 2'd2;
   localparam logic [COLOR_W-1:0] LAMP_YELLOW = 2'd3;

   localparam logic [COUNT_W-1:0] NS_PED_SECS      = 4'd7;
   localparam logic [COUNT_W-1:0] EW_PED_SECS      = 4'd8;
   localparam logic [COUNT_W-1:0] NS_GREEN_SECS    = 4'd6;
   localparam logic [COUNT_W-1:0] EW_GREEN_SECS    = 4'd7;
   localparam logic [COUNT_W-1:0] LEFT_DAY_SECS    = 4'd8;
   localparam logic [COUNT_W-1:0] LEFT_NIGHT_SECS  = 4'd5;
   localparam logic [COUNT_W-1:0] YELLOW_DAY_SECS  = 4'd3;
   localparam logic [COUNT_W-1:0] YELLOW_NIGHT_SECS = 4'd2;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [COUNT_W-1:0] secs;
      logic               cycle_day;
      logic               day_sensed;
      logic               ns_ped;
      logic               ew_ped;
      logic               fl_req;
      logic               fl_act;
      logic               fl_red;
   } ctl_state_type;

endpackage

// ===== hw/rtl/traffic_intersection_controller_top.sv =====
`timescale 1ns / 1ps
// traffic intersection controller: one second of sequencing per input word
// depends on tic_pkg

// Each input word is one second: the light reading, the button presses and the
// left turn switch levels of that second. The block answers every word with one
// result word holding the four light colors, the phase and pedestrian counts,
// the buzzer flag and the mode flags. A word is held in the input register,
// the whole second update runs as one combinational pass into the result
// register, which presents the result, and a new word is taken every cycle
// while the result side keeps up. The user must write the light threshold
// through the csr port while no word is in flight; the block does not enforce it.

module traffic_intersection_controller_top
   import tic_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // light_sample[9:0], ns_ped_press[10], ew_ped_press[11], flash_press[12],
   // ew_left_switch[13], ns_left_switch[14], zero[15]
   input  logic [REQ_W-1:0]    req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // ns_lamp[1:0], ns_left_lamp[3:2], ew_lamp[5:4], ew_left_lamp[7:6],
   // phase_count[11:8], walk_count[15:12], beep[16], day_flag[17],
   // flashing[18], flash_pending[19], zero[23:20]
   output logic [RSP_W-1:0]    rsp_tdata,
   input  logic                csr_wr_en,
   input  logic [SAMPLE_W-1:0] csr_wr_data
);

   typedef enum logic [PHASE_W-1:0] {
      PH_START  = 5'd0,
      PH_NS_PED = 5'd1,
      PH_NS_G   = 5'd2,
      PH_NS_Y   = 5'd3,
      PH_EWL_G  = 5'd4,
      PH_EWL_Y  = 5'd5,
      PH_EW_PED = 5'd6,
      PH_EW_G   = 5'd7,
      PH_EW_Y   = 5'd8,
      PH_NSL_G  = 5'd9,
      PH_NSL_Y  = 5'd10,
      PH_FLASH  = 5'd11
   } phase_type;

   function automatic ctl_state_type advance(input ctl_state_type s,
                                             input logic ewl_sw,
                                             input logic nsl_sw);
      ctl_state_type      r;
      logic [COUNT_W-1:0] yel;
      logic [PHASE_W-1:0] ew_phase;
      logic [COUNT_W-1:0] ew_secs;
      r   = s;
      yel = s.cycle_day ? YELLOW_DAY_SECS : YELLOW_NIGHT_SECS;
      if (s.cycle_day && s.ew_ped) begin
         ew_phase = PH_EW_PED;
         ew_secs  = EW_PED_SECS;
      end else begin
         ew_phase = PH_EW_G;
         ew_secs  = EW_GREEN_SECS;
      end
      if (s.secs == '0 && s.phase != PH_FLASH) begin
         unique case (phase_type'(s.phase))
            PH_NS_PED: begin
               r.ns_ped = 1'b0;
               r.phase  = PH_NS_G;
               r.secs   = NS_GREEN_SECS;
            end
            PH_NS_G: begin
               r.phase = PH_NS_Y;
               r.secs  = yel;
            end
            PH_NS_Y: begin
               if (ewl_sw) begin
                  r.phase = PH_EWL_G;
                  r.secs  = s.cycle_day ? LEFT_DAY_SECS : LEFT_NIGHT_SECS;
               end else begin
                  r.phase = ew_phase;
                  r.secs  = ew_secs;
               end
            end
            PH_EWL_G: begin
               r.phase = PH_EWL_Y;
               r.secs  = yel;
            end
            PH_EWL_Y: begin
               r.phase = ew_phase;
               r.secs  = ew_secs;
            end
            PH_EW_PED: begin
               r.ew_ped = 1'b0;
               r.phase  = PH_EW_G;
               r.secs   = EW_GREEN_SECS;
            end
            PH_EW_G: begin
               r.phase = PH_EW_Y;
               r.secs  = yel;
            end
            PH_EW_Y: begin
               if (nsl_sw) begin
                  r.phase = PH_NSL_G;
                  r.secs  = LEFT_DAY_SECS;
               end else begin
                  r.phase = PH_START;
                  r.secs  = '0;
               end
            end
            PH_NSL_G: begin
               r.phase = PH_NSL_Y;
               r.secs  = yel;
            end
            PH_START, PH_NSL_Y: begin
               if (s.fl_req) begin
                  r.fl_req = 1'b0;
                  r.fl_act = 1'b1;
                  r.fl_red = 1'b1;
                  r.phase  = PH_FLASH;
                  r.secs   = '0;
               end else begin
                  r.cycle_day = s.day_sensed;
                  if (!s.day_sensed) begin
                     r.ns_ped = 1'b0;
                     r.ew_ped = 1'b0;
                  end
                  if (s.day_sensed && s.ns_ped) begin
                     r.phase = PH_NS_PED;
                     r.secs  = NS_PED_SECS;
                  end else begin
                     r.phase = PH_NS_G;
                     r.secs  = NS_GREEN_SECS;
                  end
               end
            end
            default: begin
               r.phase = PH_START;
               r.secs  = '0;
            end
         endcase
      end
      return r;
   endfunction

   logic [SAMPLE_W-1:0] threshold_ff;
   logic                s1_valid_ff;
   logic [REQ_W-2:0]    s1_data_ff;
   logic                rsp_valid_ff;
   logic [RSP_W-1:0]    rsp_data_ff;
   logic [RSP_W-1:0]    rsp_data_in;
   ctl_state_type       state_ff;
   ctl_state_type       state_in;
   ctl_state_type       st_exit;
   ctl_state_type       st_one;
   ctl_state_type       st_res;
   logic                advance_en;

   logic [SAMPLE_W-1:0] sample;
   logic                ns_press;
   logic                ew_press;
   logic                fl_press;
   logic                ewl_sw;
   logic                nsl_sw;
   logic [COLOR_W-1:0]  ns_col;
   logic [COLOR_W-1:0]  nsl_col;
   logic [COLOR_W-1:0]  ew_col;
   logic [COLOR_W-1:0]  ewl_col;
   logic [COUNT_W-1:0]  pcount;
   logic [COUNT_W-1:0]  pedc;
   logic                beep;

   assign advance_en = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance_en;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign sample   = s1_data_ff[9:0];
   assign ns_press = s1_data_ff[10];
   assign ew_press = s1_data_ff[11];
   assign fl_press = s1_data_ff[12];
   assign ewl_sw   = s1_data_ff[13];
   assign nsl_sw   = s1_data_ff[14];

   // flash exit before a red second, then up to two phase steps
   always_comb begin
      st_exit = state_ff;
      if (state_ff.phase == PH_FLASH && state_ff.fl_red && state_ff.fl_req) begin
         st_exit.fl_req = 1'b0;
         st_exit.fl_act = 1'b0;
         st_exit.phase  = PH_START;
         st_exit.secs   = '0;
      end
      st_one = advance(st_exit, ewl_sw, nsl_sw);
      st_res = advance(st_one, ewl_sw, nsl_sw);
   end

   always_comb begin
      ns_col  = LAMP_RED;
      nsl_col = LAMP_RED;
      ew_col  = LAMP_RED;
      ewl_col = LAMP_RED;
      pcount  = '0;
      pedc    = '0;
      beep    = 1'b0;
      unique case (phase_type'(st_res.phase))
         PH_NS_PED: begin
            ns_col = LAMP_GREEN;
            pedc   = st_res.secs - 4'd1;
            beep   = 1'b1;
         end
         PH_NS_G: begin
            ns_col = LAMP_GREEN;
            pcount = st_res.secs;
         end
         PH_NS_Y: begin
            ns_col = LAMP_YELLOW;
            pcount = st_res.secs;
         end
         PH_EWL_G: begin
            ewl_col = LAMP_GREEN;
            pcount  = st_res.secs;
         end
         PH_EWL_Y: begin
            ewl_col = LAMP_YELLOW;
            pcount  = st_res.secs;
         end
         PH_EW_PED: begin
            ew_col = LAMP_GREEN;
            pedc   = st_res.secs - 4'd1;
            beep   = 1'b1;
         end
         PH_EW_G: begin
            ew_col = LAMP_GREEN;
            pcount = st_res.secs;
         end
         PH_EW_Y: begin
            ew_col = LAMP_YELLOW;
            pcount = st_res.secs;
         end
         PH_NSL_G: begin
            nsl_col = LAMP_GREEN;
            pcount  = st_res.secs;
         end
         PH_NSL_Y: begin
            nsl_col = LAMP_YELLOW;
            pcount  = st_res.secs;
         end
         PH_FLASH: begin
            if (!st_res.fl_red) begin
               ns_col  = LAMP_OFF;
               nsl_col = LAMP_OFF;
               ew_col  = LAMP_OFF;
               ewl_col = LAMP_OFF;
            end
         end
         default: begin
         end
      endcase

      rsp_data_in = {4'b0000, st_res.fl_req, st_res.fl_act, st_res.cycle_day, beep,
                     pedc, pcount, ewl_col, ew_col, nsl_col, ns_col};

      // end of second: latch presses, take the light reading, tick the timer (or toggle red/dark while flashing)
      state_in = st_res;
      if (ns_press) begin
         state_in.ns_ped = st_res.cycle_day;
      end
      if (ew_press) begin
         state_in.ew_ped = st_res.cycle_day;
      end
      if (fl_press) begin
         state_in.fl_req = 1'b1;
      end
      state_in.day_sensed = sample < threshold_ff;
      if (st_res.phase == PH_FLASH) begin
         state_in.fl_red = !st_res.fl_red;
      end else if (st_res.secs != '0) begin
         state_in.secs = st_res.secs - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff       <= THRESHOLD_RESET;
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         state_ff.phase      <= PH_START;
         state_ff.secs       <= '0;
         state_ff.cycle_day  <= 1'b1;
         state_ff.day_sensed <= 1'b1;
         state_ff.ns_ped     <= 1'b0;
         state_ff.ew_ped     <= 1'b0;
         state_ff.fl_req     <= 1'b0;
         state_ff.fl_act     <= 1'b0;
         state_ff.fl_red     <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (req_tready && req_tvalid) begin
            s1_data_ff <= req_tdata[REQ_W-2:0];
         end
         if (advance_en) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= rsp_data_in;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // flash activity and the flash phase go together
   assert property (@(posedge clock) disable iff (reset)
      state_ff.fl_act == (state_ff.phase == PH_FLASH))
      else $error("flash flag out of step with phase");

   // no counts or beep while flashing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[18] |-> rsp_data_ff[16:8] == '0)
      else $error("counts shown while flashing");

   // pedestrian countdown only in day cycles and never with a phase count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[16] |-> rsp_data_ff[17] && rsp_data_ff[11:8] == '0)
      else $error("pedestrian beep outside a day countdown");

   // a moving ns movement keeps the ew lights red
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[1:0] == LAMP_GREEN || rsp_data_ff[1:0] == LAMP_YELLOW)
      |-> rsp_data_ff[5:4] == LAMP_RED && rsp_data_ff[7:6] == LAMP_RED)
      else $error("conflicting greens");

   // a result is produced whenever the input stage moves on
   assert property (@(posedge clock) disable iff (reset)
      advance_en |=> rsp_valid_ff)
      else $error("result word lost");

endmodule
